// ===== src/pcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared widths, reset values, codes and types of the PI duty controller.
// ----------------------------------------------------------------------------
package pcpd_pkg;

  // ADC sample width
  localparam int SAMPLE_BITS = 12;

  // configuration register widths
  localparam int KP_W       = 24;  // Q8.16
  localparam int ITS_W      = 24;  // Q0.24
  localparam int LIM_W      = 20;  // Q4.16
  localparam int PER_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration reset values
  localparam logic [KP_W-1:0]  KP_RST  = KP_W'(3276800);
  localparam logic [ITS_W-1:0] ITS_RST = ITS_W'(16777);
  localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(458752);
  localparam logic [PER_W-1:0] PER_RST = PER_W'(399);

  // control action, signed Q4.16
  localparam int ACT_W = 21;

  // error e and its sum / difference with the previous error
  localparam int EW     = SAMPLE_BITS + 1;
  localparam int DW     = SAMPLE_BITS + 2;
  localparam int DCNT_W = $clog2(DW);

  // gain product kp * integ_ts
  localparam int KI_W   = KP_W + ITS_W;
  localparam int KCNT_W = $clog2(ITS_W);

  // proportional and integral products, integral shift (24 + 1 for the /2)
  localparam int PW      = KP_W + DW;
  localparam int IW      = KI_W + DW;
  localparam int I_SHIFT = 25;
  localparam int ITW     = IW - I_SHIFT;
  localparam int SUMW    = PW + 2;

  // duty scaling: period * (u + limit), then divide by 2 * limit
  localparam int NUM_W  = PER_W + ACT_W;
  localparam int SCNT_W = $clog2(PER_W);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP           = 2'd0,
    CFG_INTEG_TS     = 2'd1,
    CFG_OUTPUT_LIMIT = 2'd2,
    CFG_PWM_PERIOD   = 2'd3
  } cfg_idx_t;

  // top level sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PI,
    ST_SCALE,
    ST_HOLD
  } ctrl_state_t;

  // PI core phases
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_SUM,
    CORE_CLAMP
  } core_phase_t;

  // duty scaler phases
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } scale_phase_t;

  // PI core result
  typedef struct packed {
    logic signed [ACT_W-1:0] action;
    logic                    clamped;
  } pi_result_t;

endpackage

// ===== src/pcpd_gain_mul.sv =====
// ----------------------------------------------------------------------------
// pcpd_gain_mul
// Bit-serial product kp * integ_ts, rerun after reset and after either
// register is written. One multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pcpd_gain_mul
  import pcpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [KP_W-1:0]  kp,
  input  logic [ITS_W-1:0] integ_ts,
  output logic [KI_W-1:0]  ki_full,
  output logic             ready
);

  logic              pend_r, pend_nxt;
  logic              run_r, run_nxt;
  logic [KCNT_W-1:0] cnt_r, cnt_nxt;
  logic [ITS_W-1:0]  mplr_r, mplr_nxt;
  logic [KI_W-1:0]   acc_r, acc_nxt;

  // shift-add step
  always_comb begin
    pend_nxt = restart;
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    mplr_nxt = mplr_r;
    acc_nxt  = acc_r;
    if (pend_r) begin
      run_nxt  = 1'b1;
      cnt_nxt  = KCNT_W'(ITS_W - 1);
      mplr_nxt = integ_ts;
      acc_nxt  = '0;
    end else if (run_r) begin
      acc_nxt  = (acc_r << 1) + (mplr_r[ITS_W-1] ? KI_W'(kp) : '0);
      mplr_nxt = mplr_r << 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      run_r  <= run_nxt;
      cnt_r  <= cnt_nxt;
    end
    mplr_r <= mplr_nxt;
    acc_r  <= acc_nxt;
  end

  assign ki_full = acc_r;
  assign ready   = !pend_r && !run_r;

endmodule

// ===== src/pcpd_pi_core.sv =====
// ----------------------------------------------------------------------------
// pcpd_pi_core
// Tustin PI update with clamp. The proportional and integral products run
// side by side, one bit of (e - e_prev) and (e + e_prev) per cycle, MSB
// first; then a sum step and a clamp step. Holds e_prev and u_prev.
// ----------------------------------------------------------------------------
module pcpd_pi_core
  import pcpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] setpoint,
  input  logic [SAMPLE_BITS-1:0] feedback,
  input  logic [KP_W-1:0]        kp,
  input  logic [KI_W-1:0]        ki_full,
  input  logic [LIM_W-1:0]       lim,
  output logic                   done,
  output pi_result_t             res
);

  core_phase_t              phase_r, phase_nxt;
  logic [DCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                     done_r, done_nxt;
  logic                     flag_r, flag_nxt;
  logic signed [EW-1:0]     err_r, err_nxt;
  logic signed [EW-1:0]     last_err_r, last_err_nxt;
  logic signed [ACT_W-1:0]  last_act_r, last_act_nxt;
  logic [DW-1:0]            dm_r, dm_nxt;
  logic [DW-1:0]            sm_r, sm_nxt;
  logic signed [PW-1:0]     pacc_r, pacc_nxt;
  logic signed [IW-1:0]     iacc_r, iacc_nxt;
  logic signed [SUMW-1:0]   sum_r, sum_nxt;

  logic signed [EW-1:0]     err_in;
  logic signed [DW-1:0]     diff_in, sum_in;
  logic signed [PW-1:0]     kp_s, p_add;
  logic signed [IW-1:0]     ki_s, i_add;
  logic signed [ITW-1:0]    i_term;
  logic signed [SUMW-1:0]   lim_s, u_cl;
  logic                     first_bit;

  // error terms formed at the transfer
  assign err_in  = signed'({1'b0, setpoint}) - signed'({1'b0, feedback});
  assign diff_in = DW'(err_in) - DW'(last_err_r);
  assign sum_in  = DW'(err_in) + DW'(last_err_r);

  // partial products; the sign bit of the multiplier has negative weight
  assign kp_s      = signed'(PW'(kp));
  assign ki_s      = signed'(IW'(ki_full));
  assign first_bit = (cnt_r == DCNT_W'(DW - 1));
  assign p_add     = dm_r[DW-1] ? (first_bit ? -kp_s : kp_s) : '0;
  assign i_add     = sm_r[DW-1] ? (first_bit ? -ki_s : ki_s) : '0;

  // integral term, floor shift
  assign i_term = signed'(iacc_r[IW-1:I_SHIFT]);
  assign lim_s  = signed'(SUMW'(lim));

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    done_nxt     = 1'b0;
    flag_nxt     = flag_r;
    err_nxt      = err_r;
    last_err_nxt = last_err_r;
    last_act_nxt = last_act_r;
    dm_nxt       = dm_r;
    sm_nxt       = sm_r;
    pacc_nxt     = pacc_r;
    iacc_nxt     = iacc_r;
    sum_nxt      = sum_r;
    u_cl         = sum_r;

    case (phase_r)
      CORE_IDLE: begin
        if (start) begin
          err_nxt   = err_in;
          dm_nxt    = diff_in;
          sm_nxt    = sum_in;
          pacc_nxt  = '0;
          iacc_nxt  = '0;
          cnt_nxt   = DCNT_W'(DW - 1);
          phase_nxt = CORE_MUL;
        end
      end
      CORE_MUL: begin
        pacc_nxt = (pacc_r <<< 1) + p_add;
        iacc_nxt = (iacc_r <<< 1) + i_add;
        dm_nxt   = dm_r << 1;
        sm_nxt   = sm_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          phase_nxt = CORE_SUM;
        end
      end
      CORE_SUM: begin
        sum_nxt   = SUMW'(last_act_r) + SUMW'(pacc_r) + SUMW'(i_term);
        phase_nxt = CORE_CLAMP;
      end
      CORE_CLAMP: begin
        // limit to +/- lim; exactly at the limit is not flagged
        flag_nxt = 1'b0;
        if (sum_r > lim_s) begin
          u_cl     = lim_s;
          flag_nxt = 1'b1;
        end else if (sum_r < -lim_s) begin
          u_cl     = -lim_s;
          flag_nxt = 1'b1;
        end
        last_act_nxt = signed'(u_cl[ACT_W-1:0]);
        last_err_nxt = err_r;
        done_nxt     = 1'b1;
        phase_nxt    = CORE_IDLE;
      end
      default: begin
        phase_nxt = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= CORE_IDLE;
      cnt_r      <= '0;
      done_r     <= 1'b0;
      flag_r     <= 1'b0;
      last_err_r <= '0;
      last_act_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      done_r     <= done_nxt;
      flag_r     <= flag_nxt;
      last_err_r <= last_err_nxt;
      last_act_r <= last_act_nxt;
    end
    err_r  <= err_nxt;
    dm_r   <= dm_nxt;
    sm_r   <= sm_nxt;
    pacc_r <= pacc_nxt;
    iacc_r <= iacc_nxt;
    sum_r  <= sum_nxt;
  end

  assign done        = done_r;
  assign res.action  = last_act_r;
  assign res.clamped = flag_r;

endmodule

// ===== src/pcpd_duty_scale.sv =====
// ----------------------------------------------------------------------------
// pcpd_duty_scale
// Compare value floor(period * (u + lim) / (2 * lim)): bit-serial multiply
// over the period bits, then restoring division, one quotient bit a cycle.
// A zero limit gives the mid-scale value period / 2, skipping both steps.
// ----------------------------------------------------------------------------
module pcpd_duty_scale
  import pcpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACT_W-1:0] action,
  input  logic [LIM_W-1:0]        lim,
  input  logic [PER_W-1:0]        period,
  output logic                    done,
  output logic [PER_W-1:0]        compare
);

  scale_phase_t      phase_r, phase_nxt;
  logic [SCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [PER_W-1:0]  per_r, per_nxt;
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  den_r, den_nxt;
  logic [PER_W-1:0]  quo_r, quo_nxt;

  logic [ACT_W-1:0]  act_u;
  logic [ACT_W-1:0]  offs;
  logic              fits;

  // u + lim lies in 0 .. 2*lim, so the modular add is exact
  assign act_u = action;
  assign offs  = act_u + ACT_W'(lim);
  assign fits  = (rem_r >= den_r);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    per_nxt   = per_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;

    case (phase_r)
      SC_IDLE: begin
        if (start) begin
          if (lim == '0) begin
            quo_nxt  = period >> 1;
            done_nxt = 1'b1;
          end else begin
            per_nxt   = period;
            rem_nxt   = '0;
            den_nxt   = NUM_W'({lim, {PER_W{1'b0}}});
            quo_nxt   = '0;
            cnt_nxt   = SCNT_W'(PER_W - 1);
            phase_nxt = SC_MUL;
          end
        end
      end
      // numerator, MSB of the period first
      SC_MUL: begin
        rem_nxt = (rem_r << 1) + (per_r[PER_W-1] ? NUM_W'(offs) : '0);
        per_nxt = per_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = SCNT_W'(PER_W - 1);
          phase_nxt = SC_DIV;
        end
      end
      // divisor starts at (2*lim) << (PER_W-1) and walks down
      SC_DIV: begin
        if (fits) begin
          rem_nxt = rem_r - den_r;
        end
        quo_nxt = {quo_r[PER_W-2:0], fits};
        den_nxt = den_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          phase_nxt = SC_IDLE;
        end
      end
      default: begin
        phase_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SC_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    per_r <= per_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done    = done_r;
  assign compare = quo_r;

endmodule

// ===== src/pi_control_pwm_duty.sv =====
// ----------------------------------------------------------------------------
// pi_control_pwm_duty
// From input transfer to out_valid: 14 serial PI steps, sum, clamp,
//   16 multiply and 16 divide steps (a zero limit skips the last two).
// A new sample is taken only after the last result is loaded for output.
// The gain product kp*integ_ts is rebuilt after reset and after a kp or
//   integ_ts write; in_ready is low meanwhile. Reset clears control state.
// ----------------------------------------------------------------------------
module pi_control_pwm_duty
  import pcpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  in_setpoint_sample,
  input  logic [SAMPLE_BITS-1:0]  in_feedback_sample,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACT_W-1:0] out_control_action,
  output logic [PER_W-1:0]        out_compare_value,
  output logic                    out_clamped
);

  logic [KP_W-1:0]         kp_r;
  logic [ITS_W-1:0]        its_r;
  logic [LIM_W-1:0]        lim_r;
  logic [PER_W-1:0]        per_r;

  ctrl_state_t             state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [ACT_W-1:0] out_act_r;
  logic [PER_W-1:0]        out_cmp_r;
  logic                    out_clamp_r;

  logic                    gain_restart;
  logic [KI_W-1:0]         ki_full;
  logic                    gain_ready;
  logic                    in_xfer;
  logic                    core_done;
  pi_result_t              core_res;
  logic                    scale_done;
  logic [PER_W-1:0]        scale_cmp;
  logic                    load_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= KP_RST;
      its_r <= ITS_RST;
      lim_r <= LIM_RST;
      per_r <= PER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KP:           kp_r  <= cfg_wdata[KP_W-1:0];
        CFG_INTEG_TS:     its_r <= cfg_wdata[ITS_W-1:0];
        CFG_OUTPUT_LIMIT: lim_r <= cfg_wdata[LIM_W-1:0];
        CFG_PWM_PERIOD:   per_r <= cfg_wdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // gain product is rebuilt when either factor changes
  assign gain_restart = cfg_wr_en &&
                        ((cfg_idx_t'(cfg_index) == CFG_KP) ||
                         (cfg_idx_t'(cfg_index) == CFG_INTEG_TS));

  pcpd_gain_mul u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (gain_restart),
    .kp       (kp_r),
    .integ_ts (its_r),
    .ki_full  (ki_full),
    .ready    (gain_ready)
  );

  assign in_xfer = in_valid && in_ready;

  pcpd_pi_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .setpoint (in_setpoint_sample),
    .feedback (in_feedback_sample),
    .kp       (kp_r),
    .ki_full  (ki_full),
    .lim      (lim_r),
    .done     (core_done),
    .res      (core_res)
  );

  pcpd_duty_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (core_done),
    .action  (core_res.action),
    .lim     (lim_r),
    .period  (per_r),
    .done    (scale_done),
    .compare (scale_cmp)
  );

  // sequencing and output register control
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        in_ready = gain_ready;
        if (in_xfer) begin
          state_nxt = ST_PI;
        end
      end
      ST_PI: begin
        if (core_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          if (!out_valid_r || out_ready) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      out_act_r   <= core_res.action;
      out_clamp_r <= core_res.clamped;
      out_cmp_r   <= scale_cmp;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_control_action = out_act_r;
  assign out_compare_value  = out_cmp_r;
  assign out_clamped        = out_clamp_r;

endmodule
